### rtl/core/nth_expression_parser_macros.svh
// Assertion macros used by the checker of the an+b expression parser.
`ifndef NTH_EXPRESSION_PARSER_MACROS_SVH
`define NTH_EXPRESSION_PARSER_MACROS_SVH

// The condition implies the consequence at the same clock edge, outside reset.
`define NEP_ASSERT_SAME(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// The condition implies the consequence at the next clock edge, outside reset.
`define NEP_ASSERT_NEXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

// The condition implies the consequence at the next clock edge, reset included.
`define NEP_ASSERT_ALWAYS_NEXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) (cond) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/nep_pkg.sv
// Types, character codes and helper functions of the an+b expression parser.
package nep_pkg;

  localparam int NUM_WIDTH = 16;
  localparam int MAG_W     = NUM_WIDTH - 1;
  localparam int ACC_W     = MAG_W + 4;

  typedef logic [MAG_W-1:0]            mag_t;
  typedef logic signed [NUM_WIDTH-1:0] num_t;
  typedef logic [7:0]                  char_t;
  typedef logic [2:0]                  kw_pos_t;

  localparam mag_t NUM_MAX = '1;

  localparam char_t CH_SPACE = 8'h20;
  localparam char_t CH_PLUS  = 8'h2B;
  localparam char_t CH_MINUS = 8'h2D;
  localparam char_t CH_ZERO  = 8'h30;
  localparam char_t CH_NINE  = 8'h39;
  localparam char_t CH_D     = 8'h64;
  localparam char_t CH_E     = 8'h65;
  localparam char_t CH_N     = 8'h6E;
  localparam char_t CH_O     = 8'h6F;
  localparam char_t CH_V     = 8'h76;

  typedef enum logic [3:0] {
    PH_START,
    PH_LEAD,
    PH_KW,
    PH_KWTAIL,
    PH_BNUM,
    PH_BTAIL,
    PH_AFTER_N,
    PH_OSIGN,
    PH_ODIG,
    PH_OTAIL
  } phase_t;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_EVEN,
    KIND_ODD
  } kind_t;

  typedef struct packed {
    char_t ch;
    logic  has_char;
    logic  last;
  } in_item_t;

  typedef struct packed {
    logic ok;
    num_t base_a;
    num_t offset_b;
  } out_item_t;

  function automatic logic is_digit(char_t c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // Multiplies the magnitude by ten, adds the digit and saturates.
  function automatic mag_t acc10(mag_t acc, char_t c);
    logic [ACC_W-1:0] wide;
    logic [ACC_W-1:0] v;
    wide = {4'b0000, acc};
    v = (wide << 3) + (wide << 1) + {{MAG_W{1'b0}}, c[3:0]};
    if (v > {4'b0000, NUM_MAX}) begin
      return NUM_MAX;
    end
    return v[MAG_W-1:0];
  endfunction

  function automatic kw_pos_t kw_len(kind_t kind);
    return (kind == KIND_EVEN) ? kw_pos_t'(4) : kw_pos_t'(3);
  endfunction

  function automatic char_t kw_char(kind_t kind, kw_pos_t pos);
    char_t c;
    c = CH_SPACE;
    if (kind == KIND_EVEN) begin
      unique case (pos)
        3'd0, 3'd2: c = CH_E;
        3'd1:       c = CH_V;
        3'd3:       c = CH_N;
        default:    c = CH_SPACE;
      endcase
    end else begin
      unique case (pos)
        3'd0:       c = CH_O;
        3'd1, 3'd2: c = CH_D;
        default:    c = CH_SPACE;
      endcase
    end
    return c;
  endfunction

  function automatic num_t encode(logic neg, mag_t mag);
    num_t m;
    m = {1'b0, mag};
    return neg ? -m : m;
  endfunction

endpackage

### rtl/core/nth_expression_parser.sv
// Top level of the character-serial an+b expression parser.
//
//  channel | direction | payload             | handshake
//  in_     | input     | nep_pkg::in_item_t  | in_valid / in_stall
//  out_    | output    | nep_pkg::out_item_t | out_valid / out_stall
//
// Each item is parsed in its accepting cycle, one per clock unless stalled.
// A result is registered when its last item is accepted.
// An output register and a skid register hold results while out_stall is high.
// in_stall rises only when the skid register is occupied.
// Reset clears the parse state and the valid flags of both result registers.
module nth_expression_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  nep_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output nep_pkg::out_item_t  out_data
);

  nep_pkg::phase_t    phase_r, phase_nxt, fd_phase;
  nep_pkg::kind_t     kw_kind_r, kw_kind_nxt, fd_kw_kind;
  nep_pkg::kw_pos_t   kw_pos_r, kw_pos_nxt, fd_kw_pos;
  logic               base_neg_r, base_neg_nxt, fd_base_neg;
  logic               base_dig_r, base_dig_nxt, fd_base_dig;
  nep_pkg::mag_t      base_acc_r, base_acc_nxt, fd_base_acc;
  logic               off_neg_r, off_neg_nxt, fd_off_neg;
  nep_pkg::mag_t      off_acc_r, off_acc_nxt, fd_off_acc;
  logic               err_r, err_nxt, fd_err;

  logic               accept;
  logic               produce;
  nep_pkg::out_item_t res;

  logic               out_valid_r, out_valid_nxt;
  nep_pkg::out_item_t out_data_r, out_data_nxt;
  logic               skid_valid_r, skid_valid_nxt;
  nep_pkg::out_item_t skid_data_r, skid_data_nxt;

  nep_pkg::char_t     c;

  assign c        = in_data.ch;
  assign in_stall = skid_valid_r;
  assign accept   = in_valid && !in_stall;
  assign produce  = accept && in_data.last;

  always_comb begin
    fd_phase    = phase_r;
    fd_kw_kind  = kw_kind_r;
    fd_kw_pos   = kw_pos_r;
    fd_base_neg = base_neg_r;
    fd_base_dig = base_dig_r;
    fd_base_acc = base_acc_r;
    fd_off_neg  = off_neg_r;
    fd_off_acc  = off_acc_r;
    fd_err      = err_r;
    if (in_data.has_char && !err_r) begin
      unique case (phase_r)
        nep_pkg::PH_START, nep_pkg::PH_LEAD: begin
          if (c == nep_pkg::CH_SPACE) begin
            fd_phase = nep_pkg::PH_LEAD;
          end else if (c == nep_pkg::CH_E) begin
            fd_phase   = nep_pkg::PH_KW;
            fd_kw_kind = nep_pkg::KIND_EVEN;
            fd_kw_pos  = nep_pkg::kw_pos_t'(1);
          end else if (c == nep_pkg::CH_O) begin
            fd_phase   = nep_pkg::PH_KW;
            fd_kw_kind = nep_pkg::KIND_ODD;
            fd_kw_pos  = nep_pkg::kw_pos_t'(1);
          end else if (c == nep_pkg::CH_PLUS || c == nep_pkg::CH_MINUS) begin
            fd_phase    = nep_pkg::PH_BNUM;
            fd_base_neg = (c == nep_pkg::CH_MINUS);
          end else if (nep_pkg::is_digit(c)) begin
            fd_phase    = nep_pkg::PH_BNUM;
            fd_base_dig = 1'b1;
            fd_base_acc = nep_pkg::acc10('0, c);
          end else if (c == nep_pkg::CH_N) begin
            fd_phase    = nep_pkg::PH_AFTER_N;
            fd_base_acc = nep_pkg::mag_t'(1);
          end else begin
            fd_err = 1'b1;
          end
        end
        nep_pkg::PH_KW: begin
          if (kw_pos_r < nep_pkg::kw_len(kw_kind_r) &&
              c == nep_pkg::kw_char(kw_kind_r, kw_pos_r)) begin
            fd_kw_pos = kw_pos_r + nep_pkg::kw_pos_t'(1);
            if (fd_kw_pos == nep_pkg::kw_len(kw_kind_r)) begin
              fd_phase = nep_pkg::PH_KWTAIL;
            end
          end else begin
            fd_err = 1'b1;
          end
        end
        nep_pkg::PH_KWTAIL, nep_pkg::PH_BTAIL, nep_pkg::PH_OTAIL: begin
          if (c != nep_pkg::CH_SPACE) begin
            fd_err = 1'b1;
          end
        end
        nep_pkg::PH_BNUM: begin
          if (nep_pkg::is_digit(c)) begin
            fd_base_dig = 1'b1;
            fd_base_acc = nep_pkg::acc10(base_acc_r, c);
          end else if (c == nep_pkg::CH_N) begin
            if (!base_dig_r) begin
              fd_base_acc = nep_pkg::mag_t'(1);
            end
            fd_phase = nep_pkg::PH_AFTER_N;
          end else if (c == nep_pkg::CH_SPACE && base_dig_r) begin
            fd_phase = nep_pkg::PH_BTAIL;
          end else begin
            fd_err = 1'b1;
          end
        end
        nep_pkg::PH_AFTER_N: begin
          if (c == nep_pkg::CH_PLUS || c == nep_pkg::CH_MINUS) begin
            fd_phase   = nep_pkg::PH_OSIGN;
            fd_off_neg = (c == nep_pkg::CH_MINUS);
          end else if (c != nep_pkg::CH_SPACE) begin
            fd_err = 1'b1;
          end
        end
        nep_pkg::PH_OSIGN: begin
          if (nep_pkg::is_digit(c)) begin
            fd_phase   = nep_pkg::PH_ODIG;
            fd_off_acc = nep_pkg::acc10('0, c);
          end else if (c != nep_pkg::CH_SPACE) begin
            fd_err = 1'b1;
          end
        end
        nep_pkg::PH_ODIG: begin
          if (nep_pkg::is_digit(c)) begin
            fd_off_acc = nep_pkg::acc10(off_acc_r, c);
          end else if (c == nep_pkg::CH_SPACE) begin
            fd_phase = nep_pkg::PH_OTAIL;
          end else begin
            fd_err = 1'b1;
          end
        end
        default: begin
          fd_err = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    res.ok       = 1'b0;
    res.base_a   = '0;
    res.offset_b = '0;
    if (!fd_err) begin
      unique case (fd_phase)
        nep_pkg::PH_LEAD: begin
          res.ok = 1'b1;
        end
        nep_pkg::PH_KWTAIL: begin
          res.ok       = 1'b1;
          res.base_a   = nep_pkg::encode(1'b0, nep_pkg::mag_t'(2));
          res.offset_b = nep_pkg::encode(1'b0,
                           (fd_kw_kind == nep_pkg::KIND_ODD) ? nep_pkg::mag_t'(1) : '0);
        end
        nep_pkg::PH_BNUM: begin
          if (fd_base_dig) begin
            res.ok       = 1'b1;
            res.offset_b = nep_pkg::encode(fd_base_neg, fd_base_acc);
          end
        end
        nep_pkg::PH_BTAIL: begin
          res.ok       = 1'b1;
          res.offset_b = nep_pkg::encode(fd_base_neg, fd_base_acc);
        end
        nep_pkg::PH_AFTER_N: begin
          res.ok     = 1'b1;
          res.base_a = nep_pkg::encode(fd_base_neg, fd_base_acc);
        end
        nep_pkg::PH_ODIG, nep_pkg::PH_OTAIL: begin
          res.ok       = 1'b1;
          res.base_a   = nep_pkg::encode(fd_base_neg, fd_base_acc);
          res.offset_b = nep_pkg::encode(fd_off_neg, fd_off_acc);
        end
        default: begin
          res.ok = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    phase_nxt    = phase_r;
    kw_kind_nxt  = kw_kind_r;
    kw_pos_nxt   = kw_pos_r;
    base_neg_nxt = base_neg_r;
    base_dig_nxt = base_dig_r;
    base_acc_nxt = base_acc_r;
    off_neg_nxt  = off_neg_r;
    off_acc_nxt  = off_acc_r;
    err_nxt      = err_r;
    if (produce) begin
      phase_nxt    = nep_pkg::PH_START;
      kw_kind_nxt  = nep_pkg::KIND_NONE;
      kw_pos_nxt   = '0;
      base_neg_nxt = 1'b0;
      base_dig_nxt = 1'b0;
      base_acc_nxt = '0;
      off_neg_nxt  = 1'b0;
      off_acc_nxt  = '0;
      err_nxt      = 1'b0;
    end else if (accept) begin
      phase_nxt    = fd_phase;
      kw_kind_nxt  = fd_kw_kind;
      kw_pos_nxt   = fd_kw_pos;
      base_neg_nxt = fd_base_neg;
      base_dig_nxt = fd_base_dig;
      base_acc_nxt = fd_base_acc;
      off_neg_nxt  = fd_off_neg;
      off_acc_nxt  = fd_off_acc;
      err_nxt      = fd_err;
    end
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = produce;
        out_data_nxt  = res;
      end
    end else if (produce) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= nep_pkg::PH_START;
      kw_kind_r    <= nep_pkg::KIND_NONE;
      kw_pos_r     <= '0;
      base_neg_r   <= 1'b0;
      base_dig_r   <= 1'b0;
      base_acc_r   <= '0;
      off_neg_r    <= 1'b0;
      off_acc_r    <= '0;
      err_r        <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      kw_kind_r    <= kw_kind_nxt;
      kw_pos_r     <= kw_pos_nxt;
      base_neg_r   <= base_neg_nxt;
      base_dig_r   <= base_dig_nxt;
      base_acc_r   <= base_acc_nxt;
      off_neg_r    <= off_neg_nxt;
      off_acc_r    <= off_acc_nxt;
      err_r        <= err_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/core/nep_checker.sv
// Port-level checker of the an+b expression parser and its bind statement.
`include "nth_expression_parser_macros.svh"

module nep_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input nep_pkg::out_item_t out_data
);

  logic stalled;
  logic rejected;
  logic parsed;
  logic nums_zero;
  logic in_range;

  assign stalled   = out_valid && out_stall;
  assign rejected  = out_valid && !out_data.ok;
  assign parsed    = out_valid && out_data.ok;
  assign nums_zero = (out_data.base_a == '0) && (out_data.offset_b == '0);
  assign in_range  = (out_data.base_a != {1'b1, {(nep_pkg::NUM_WIDTH-1){1'b0}}}) &&
                     (out_data.offset_b != {1'b1, {(nep_pkg::NUM_WIDTH-1){1'b0}}});

  `NEP_ASSERT_NEXT(a_out_hold, stalled, out_valid && $stable(out_data), "Stalled item changed.")
  `NEP_ASSERT_SAME(a_reject_zero, rejected, nums_zero, "Rejected item carries numbers.")
  `NEP_ASSERT_SAME(a_sym_range, parsed, in_range, "Result left the symmetric range.")
  `NEP_ASSERT_SAME(a_stall_full, in_stall, out_valid, "Input stalled with no item pending.")
  `NEP_ASSERT_ALWAYS_NEXT(a_reset_clear, !rst_n, !out_valid && !in_stall, "Reset left an item.")

endmodule

bind nth_expression_parser nep_checker u_nep_checker (.*);

### verif/tb.sv
// Self-checking testbench for the character-serial an+b expression parser.
`timescale 1ns / 100ps

typedef byte unsigned text_t[$];

class anb_scoreboard;
  nep_pkg::out_item_t expected_q[$];
  int                 errors;
  nep_pkg::phase_t    ph;
  nep_pkg::kind_t     kind;
  int                 kw_pos;
  bit                 base_neg;
  bit                 base_dig;
  bit                 off_neg;
  bit                 rejected;
  int                 base_mag;
  int                 off_mag;

  function new();
    errors = 0;
    clear_parse();
  endfunction

  function void clear_parse();
    ph = nep_pkg::PH_START;
    kind = nep_pkg::KIND_NONE;
    kw_pos = 0;
    base_neg = 0;
    base_dig = 0;
    off_neg = 0;
    rejected = 0;
    base_mag = 0;
    off_mag = 0;
  endfunction

  function int mac10(int acc, byte unsigned c);
    int v;
    v = acc * 10 + int'(c) - int'(nep_pkg::CH_ZERO);
    return (v > int'(nep_pkg::NUM_MAX)) ? int'(nep_pkg::NUM_MAX) : v;
  endfunction

  function nep_pkg::num_t signed_value(bit neg, int mag);
    return neg ? nep_pkg::num_t'(-mag) : nep_pkg::num_t'(mag);
  endfunction

  function void consume(byte unsigned c);
    string word;
    bit    dig;
    dig = (c >= nep_pkg::CH_ZERO) && (c <= nep_pkg::CH_NINE);
    if (rejected) return;
    case (ph)
      nep_pkg::PH_START, nep_pkg::PH_LEAD: begin
        if (c == nep_pkg::CH_SPACE) ph = nep_pkg::PH_LEAD;
        else if (c == nep_pkg::CH_E) begin
          ph = nep_pkg::PH_KW;
          kind = nep_pkg::KIND_EVEN;
          kw_pos = 1;
        end else if (c == nep_pkg::CH_O) begin
          ph = nep_pkg::PH_KW;
          kind = nep_pkg::KIND_ODD;
          kw_pos = 1;
        end else if (c == nep_pkg::CH_PLUS || c == nep_pkg::CH_MINUS) begin
          ph = nep_pkg::PH_BNUM;
          base_neg = (c == nep_pkg::CH_MINUS);
        end else if (dig) begin
          ph = nep_pkg::PH_BNUM;
          base_dig = 1;
          base_mag = mac10(0, c);
        end else if (c == nep_pkg::CH_N) begin
          ph = nep_pkg::PH_AFTER_N;
          base_mag = 1;
        end else rejected = 1;
      end
      nep_pkg::PH_KW: begin
        if (kind == nep_pkg::KIND_EVEN) word = "even";
        else word = "odd";
        if (kw_pos < word.len() && c == word[kw_pos]) begin
          kw_pos++;
          if (kw_pos == word.len()) ph = nep_pkg::PH_KWTAIL;
        end else rejected = 1;
      end
      nep_pkg::PH_KWTAIL, nep_pkg::PH_BTAIL, nep_pkg::PH_OTAIL: begin
        if (c != nep_pkg::CH_SPACE) rejected = 1;
      end
      nep_pkg::PH_BNUM: begin
        if (dig) begin
          base_dig = 1;
          base_mag = mac10(base_mag, c);
        end else if (c == nep_pkg::CH_N) begin
          if (!base_dig) base_mag = 1;
          ph = nep_pkg::PH_AFTER_N;
        end else if (c == nep_pkg::CH_SPACE && base_dig) ph = nep_pkg::PH_BTAIL;
        else rejected = 1;
      end
      nep_pkg::PH_AFTER_N: begin
        if (c == nep_pkg::CH_PLUS || c == nep_pkg::CH_MINUS) begin
          ph = nep_pkg::PH_OSIGN;
          off_neg = (c == nep_pkg::CH_MINUS);
        end else if (c != nep_pkg::CH_SPACE) rejected = 1;
      end
      nep_pkg::PH_OSIGN: begin
        if (dig) begin
          ph = nep_pkg::PH_ODIG;
          off_mag = mac10(0, c);
        end else if (c != nep_pkg::CH_SPACE) rejected = 1;
      end
      nep_pkg::PH_ODIG: begin
        if (dig) off_mag = mac10(off_mag, c);
        else if (c == nep_pkg::CH_SPACE) ph = nep_pkg::PH_OTAIL;
        else rejected = 1;
      end
      default: rejected = 1;
    endcase
  endfunction

  function void note_input(nep_pkg::in_item_t it);
    nep_pkg::out_item_t r;
    if (it.has_char) consume(it.ch);
    if (!it.last) return;
    r = '0;
    if (!rejected) begin
      case (ph)
        nep_pkg::PH_LEAD: r.ok = 1'b1;
        nep_pkg::PH_KWTAIL: begin
          r.ok = 1'b1;
          r.base_a = nep_pkg::num_t'(2);
          r.offset_b = (kind == nep_pkg::KIND_ODD) ? nep_pkg::num_t'(1) : nep_pkg::num_t'(0);
        end
        nep_pkg::PH_BNUM: begin
          if (base_dig) begin
            r.ok = 1'b1;
            r.offset_b = signed_value(base_neg, base_mag);
          end
        end
        nep_pkg::PH_BTAIL: begin
          r.ok = 1'b1;
          r.offset_b = signed_value(base_neg, base_mag);
        end
        nep_pkg::PH_AFTER_N: begin
          r.ok = 1'b1;
          r.base_a = signed_value(base_neg, base_mag);
        end
        nep_pkg::PH_ODIG, nep_pkg::PH_OTAIL: begin
          r.ok = 1'b1;
          r.base_a = signed_value(base_neg, base_mag);
          r.offset_b = signed_value(off_neg, off_mag);
        end
        default: ;
      endcase
    end
    expected_q.push_back(r);
    clear_parse();
  endfunction

  function void check_result(nep_pkg::out_item_t got);
    nep_pkg::out_item_t want;
    if (expected_q.size() == 0) begin
      errors++;
      $error("unexpected result: ok=%0d base_a=%0d offset_b=%0d",
             got.ok, got.base_a, got.offset_b);
      return;
    end
    want = expected_q.pop_front();
    if (got.ok !== want.ok) begin
      errors++;
      $error("ok: expected %0d, actual %0d", want.ok, got.ok);
    end
    if (got.base_a !== want.base_a) begin
      errors++;
      $error("base_a: expected %0d, actual %0d", want.base_a, got.base_a);
    end
    if (got.offset_b !== want.offset_b) begin
      errors++;
      $error("offset_b: expected %0d, actual %0d", want.offset_b, got.offset_b);
    end
  endfunction
endclass

module tb;
  localparam int CYCLE_LIMIT = 500000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  nep_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_stall;
  nep_pkg::out_item_t out_data;
  anb_scoreboard      sb = new();
  int                 snd_idle_pct = 9;
  int                 rcv_idle_pct = 51;
  int                 sent_chars = 0;
  int                 cycle_count = 0;

  nth_expression_parser u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < rcv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  task automatic send_item(nep_pkg::in_item_t it);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(it);
    if (it.has_char) sent_chars++;
    @(negedge clk);
  endtask

  // Sends one expression; with end_marker the last item carries no character.
  task automatic send_bytes(text_t q, bit end_marker);
    nep_pkg::in_item_t it;
    if (q.size() == 0) end_marker = 1'b1;
    foreach (q[i]) begin
      if ($urandom_range(99) < 4) begin
        it.ch = 8'($urandom);
        it.has_char = 1'b0;
        it.last = 1'b0;
        send_item(it);
      end
      it.ch = q[i];
      it.has_char = 1'b1;
      it.last = !end_marker && (i == q.size() - 1);
      send_item(it);
    end
    if (end_marker) begin
      it.ch = 8'($urandom);
      it.has_char = 1'b0;
      it.last = 1'b1;
      send_item(it);
    end
  endtask

  task automatic wait_results_drained();
    in_valid = 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic void add_text(ref text_t q, input string s);
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
  endfunction

  function automatic void add_spaces(ref text_t q, input int n);
    repeat (n) q.push_back(nep_pkg::CH_SPACE);
  endfunction

  function automatic void add_sign(ref text_t q);
    q.push_back($urandom_range(1) ? nep_pkg::CH_PLUS : nep_pkg::CH_MINUS);
  endfunction

  function automatic void add_digits(ref text_t q);
    int n;
    n = ($urandom_range(9) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 3);
    repeat (n) q.push_back(8'(nep_pkg::CH_ZERO + $urandom_range(9)));
  endfunction

  function automatic text_t random_expression(bit broken);
    text_t q;
    q = {};
    add_spaces(q, $urandom_range(0, 2));
    case ($urandom_range(0, 9))
      0: begin
        if ($urandom_range(1)) add_text(q, "even");
        else add_text(q, "odd");
        add_spaces(q, $urandom_range(0, 2));
      end
      1: add_spaces(q, $urandom_range(0, 2));
      2: begin
        if ($urandom_range(1)) add_sign(q);
        add_digits(q);
        add_spaces(q, $urandom_range(0, 2));
      end
      default: begin
        if ($urandom_range(2) == 0) add_sign(q);
        if ($urandom_range(3) != 0) add_digits(q);
        q.push_back(nep_pkg::CH_N);
        if ($urandom_range(2) != 0) begin
          add_spaces(q, $urandom_range(0, 2));
          add_sign(q);
          add_spaces(q, $urandom_range(0, 2));
          add_digits(q);
        end
        add_spaces(q, $urandom_range(0, 2));
      end
    endcase
    if (broken) begin
      case ($urandom_range(0, 3))
        0: if (q.size() > 0) q[$urandom_range(q.size() - 1)] = 8'($urandom_range(255));
        1: if (q.size() > 0) q.delete($urandom_range(q.size() - 1));
        2: add_sign(q);
        default: begin
          q = {};
          repeat ($urandom_range(1, 6)) q.push_back(8'($urandom_range(255)));
        end
      endcase
    end
    return q;
  endfunction

  task automatic run_random(int count);
    int goal;
    goal = sent_chars + count;
    while (sent_chars < goal) begin
      send_bytes(random_expression($urandom_range(3) == 0), $urandom_range(7) == 0);
    end
  endtask

  initial begin
    string directed[$];
    text_t q;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    directed = '{"even", "  odd  ", "ev3n", "oddd", "   ", "n", "-n", "+n+3",
                 "-n- 7", "2n+1", " -3n +  12 ", "0n-0", "42", "-17  ", "+ 5",
                 "+", "3n+", "3 n", "99999n-123456", "-32768", "e", "x"};
    foreach (directed[k]) begin
      q = {};
      add_text(q, directed[k]);
      send_bytes(q, 1'b0);
    end
    q = {};
    send_bytes(q, 1'b1);
    q = {};
    add_text(q, "5n-2");
    send_bytes(q, 1'b1);
    q = '{8'(nep_pkg::CH_ZERO + 2), 8'h00, nep_pkg::CH_N};
    send_bytes(q, 1'b0);
    q = '{nep_pkg::CH_SPACE, 8'hFF};
    send_bytes(q, 1'b0);

    run_random(180);
    wait_results_drained();
    snd_idle_pct = 51;
    rcv_idle_pct = 9;
    run_random(180);
    wait_results_drained();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    run_random(180);
    wait_results_drained();
    repeat (20) @(posedge clk);

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule

### sim.f
+incdir+rtl/core
rtl/core/nep_pkg.sv
rtl/core/nth_expression_parser.sv
rtl/core/nep_checker.sv
verif/tb.sv
